/* rtl/aclp_pkg.sv */
// Shared types, character codes and keyword tables for the ASCII command line parser.
// No dependencies; every other rtl file imports this package.
package aclp_pkg;

  // Longest line held, newline excluded, is LINE_BYTES-1 bytes
  localparam int LINE_BYTES  = 64;
  localparam int LEN_W       = $clog2(LINE_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_KW      = 4;
  localparam int KWP_W       = 4;

  localparam logic [15:0] NUM_CAP = 16'd32768;
  localparam logic [15:0] POS_MAX = 16'd32767;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_D0    = 8'd48;
  localparam logic [7:0] CH_D9    = 8'd57;
  localparam logic [7:0] CH_AT    = 8'd64;

  typedef enum logic [2:0] {
    EV_COORD   = 3'd0,
    EV_CAM_ON  = 3'd1,
    EV_CAM_OFF = 3'd2,
    EV_GO      = 3'd3,
    EV_START   = 3'd4
  } ev_code_t;

  typedef enum logic [1:0] {
    LK_EMPTY = 2'd0,
    LK_HASH  = 2'd1,
    LK_AT    = 2'd2,
    LK_OTHER = 2'd3
  } line_kind_t;

  typedef enum logic [2:0] {
    PH_BLANK1 = 3'd0,
    PH_SIGN1  = 3'd1,
    PH_DIG1   = 3'd2,
    PH_BLANK2 = 3'd3,
    PH_SIGN2  = 3'd4,
    PH_DIG2   = 3'd5,
    PH_DONE   = 3'd6,
    PH_FAIL   = 3'd7
  } num_phase_t;

  // Keyword slots: 0 @cam_off, 1 @cam, 2 @go, 3 @start
  localparam logic [1:0] KW_CAM_OFF = 2'd0;
  localparam logic [1:0] KW_CAM     = 2'd1;
  localparam logic [1:0] KW_GO      = 2'd2;
  localparam logic [1:0] KW_START   = 2'd3;

  typedef struct packed {
    logic        is_coord;
    ev_code_t    code;
    logic [15:0] x;
    logic [15:0] y;
  } aclp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } aclp_qstat_t;

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] n;
    unique case (k)
      KW_CAM_OFF: n = 4'd8;
      KW_CAM:     n = 4'd4;
      KW_GO:      n = 4'd3;
      default:    n = 4'd6;
    endcase
    return n;
  endfunction

  function automatic ev_code_t kw_code(input logic [1:0] k);
    ev_code_t e;
    unique case (k)
      KW_CAM_OFF: e = EV_CAM_OFF;
      KW_CAM:     e = EV_CAM_ON;
      KW_GO:      e = EV_GO;
      default:    e = EV_START;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [KWP_W-1:0] p);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (k)
      KW_CAM_OFF: begin
        case (p)
          4'd0: ch = "@";
          4'd1: ch = "c";
          4'd2: ch = "a";
          4'd3: ch = "m";
          4'd4: ch = "_";
          4'd5: ch = "o";
          4'd6: ch = "f";
          4'd7: ch = "f";
          default: ch = CH_NUL;
        endcase
      end
      KW_CAM: begin
        case (p)
          4'd0: ch = "@";
          4'd1: ch = "c";
          4'd2: ch = "a";
          4'd3: ch = "m";
          default: ch = CH_NUL;
        endcase
      end
      KW_GO: begin
        case (p)
          4'd0: ch = "@";
          4'd1: ch = "g";
          4'd2: ch = "o";
          default: ch = CH_NUL;
        endcase
      end
      default: begin
        case (p)
          4'd0: ch = "@";
          4'd1: ch = "s";
          4'd2: ch = "t";
          4'd3: ch = "a";
          4'd4: ch = "r";
          4'd5: ch = "t";
          default: ch = CH_NUL;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

/* rtl/ascii_command_line_parser_unit.sv */
// ASCII command line parser, top level: front parser, summary queue and result back end.
// Depends on aclp_pkg, aclp_front, aclp_queue and aclp_back.
//
// The block takes one received byte per word on the in_ channel and parses newline-ended
// lines as they stream in, with no line buffer. A line starting with '#' is read as two
// comma-separated decimal numbers (leading blanks, optional sign, digits), saturated to
// 16-bit signed; when both parse, the stored coordinates are updated and a result word
// with event code 0 is sent. A line starting with '@' is scanned for @cam_off, @cam, @go
// and @start, checked in that order, and the first one found gives event code 2, 1, 3 or
// 4 with the stored coordinates unchanged. Other lines, failed parses and keyword-free
// lines send nothing. A zero byte ends a line's content; a line that would grow past
// LINE_BYTES-1 bytes is dropped together with the overflowing byte. The front parser
// updates its line state for each byte in a single step; a result word leaves through
// the summary queue and then the output register once its newline is taken. The front
// accepts a byte every cycle until the two-entry summary queue is full, which only
// happens while out_stall holds results back.
module ascii_command_line_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_event_code,
  output logic signed [15:0] out_coord_x,
  output logic signed [15:0] out_coord_y
);
  import aclp_pkg::*;

  aclp_qstat_t qstat;
  aclp_entry_t push_entry;
  aclp_entry_t head;
  logic        push;
  logic        pop;

  // Classify each byte and hold the per-line parse state
  aclp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Buffer finished lines so the front keeps going while results wait
  aclp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // Update stored coordinates and present result words
  aclp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code),
    .out_coord_x    (out_coord_x),
    .out_coord_y    (out_coord_y)
  );

endmodule

/* rtl/aclp_front.sv */
// Front end of the parser: accepts bytes, tracks line kind, number parse and keyword matches.
// Depends on aclp_pkg; pushes one finished line summary per reported line into aclp_queue.
module aclp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  output logic                 in_stall,
  input  aclp_pkg::aclp_qstat_t qstat,
  output logic                 push,
  output aclp_pkg::aclp_entry_t push_entry
);
  import aclp_pkg::*;

  logic [LEN_W-1:0]  len_r, len_nxt;
  line_kind_t        kind_r, kind_nxt;
  logic              ended_r, ended_nxt;
  num_phase_t        phase_r, phase_nxt;
  logic [15:0]       mag1_r, mag1_nxt;
  logic [15:0]       mag2_r, mag2_nxt;
  logic [1:0]        signs_r, signs_nxt;
  logic [KWP_W-1:0]  kwp_r [NUM_KW];
  logic [KWP_W-1:0]  kwp_nxt [NUM_KW];
  logic [NUM_KW-1:0] found_r, found_nxt;

  // per-byte step results, picked by the next-state block
  num_phase_t        ns_phase;
  logic [15:0]       ns_mag1, ns_mag2;
  logic [1:0]        ns_signs;
  logic [KWP_W-1:0]  ks_prog [NUM_KW];
  logic [NUM_KW-1:0] ks_found;

  logic accept, is_digit, is_sign, is_blank;
  logic [3:0] dval;

  function automatic logic [15:0] add_digit(input logic [15:0] mag, input logic [3:0] d);
    logic [18:0] v;
    v = ({3'b000, mag} << 3) + ({3'b000, mag} << 1) + {15'd0, d};
    return (v > {3'b000, NUM_CAP}) ? NUM_CAP : v[15:0];
  endfunction

  function automatic logic [15:0] finish_num(input logic [15:0] mag, input logic neg);
    logic [15:0] r;
    if (neg) r = 16'd0 - mag;
    else     r = (mag > POS_MAX) ? POS_MAX : mag;
    return r;
  endfunction

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign is_digit = (in_rx_byte >= CH_D0) && (in_rx_byte <= CH_D9);
  assign is_sign  = (in_rx_byte == CH_PLUS) || (in_rx_byte == CH_MINUS);
  assign is_blank = (in_rx_byte == CH_SPACE) ||
                    ((in_rx_byte >= CH_TAB) && (in_rx_byte <= CH_CR) && (in_rx_byte != CH_NL));
  assign dval     = in_rx_byte[3:0];

  // number parse step, "%d,%d"
  always_comb begin : num_step
    ns_phase = phase_r;
    ns_mag1  = mag1_r;
    ns_mag2  = mag2_r;
    ns_signs = signs_r;
    unique case (phase_r)
      PH_BLANK1: begin
        if (is_blank) begin
          ns_phase = phase_r;
        end else if (is_sign) begin
          if (in_rx_byte == CH_MINUS) ns_signs[0] = 1'b1;
          ns_phase = PH_SIGN1;
        end else if (is_digit) begin
          ns_mag1  = add_digit(mag1_r, dval);
          ns_phase = PH_DIG1;
        end else begin
          ns_phase = PH_FAIL;
        end
      end
      PH_BLANK2: begin
        if (is_blank) begin
          ns_phase = phase_r;
        end else if (is_sign) begin
          if (in_rx_byte == CH_MINUS) ns_signs[1] = 1'b1;
          ns_phase = PH_SIGN2;
        end else if (is_digit) begin
          ns_mag2  = add_digit(mag2_r, dval);
          ns_phase = PH_DIG2;
        end else begin
          ns_phase = PH_FAIL;
        end
      end
      PH_SIGN1: begin
        if (is_digit) begin
          ns_mag1  = add_digit(mag1_r, dval);
          ns_phase = PH_DIG1;
        end else begin
          ns_phase = PH_FAIL;
        end
      end
      PH_SIGN2: begin
        if (is_digit) begin
          ns_mag2  = add_digit(mag2_r, dval);
          ns_phase = PH_DIG2;
        end else begin
          ns_phase = PH_FAIL;
        end
      end
      PH_DIG1: begin
        if (is_digit) ns_mag1 = add_digit(mag1_r, dval);
        else          ns_phase = (in_rx_byte == CH_COMMA) ? PH_BLANK2 : PH_FAIL;
      end
      PH_DIG2: begin
        if (is_digit) ns_mag2 = add_digit(mag2_r, dval);
        else          ns_phase = PH_DONE;
      end
      default: ns_phase = phase_r;
    endcase
  end

  // keyword matchers, one per keyword, advanced side by side
  always_comb begin : kw_step
    logic [KWP_W-1:0] p;
    ks_found = found_r;
    for (int k = 0; k < NUM_KW; k++) begin
      p = kwp_r[k];
      if ((p < kw_len(2'(k))) && (in_rx_byte == kw_char(2'(k), p))) begin
        p = p + 1'b1;
      end else begin
        p = (in_rx_byte == CH_AT) ? KWP_W'(1) : KWP_W'(0);
      end
      if (p >= kw_len(2'(k))) begin
        ks_found[k] = 1'b1;
        p = '0;
      end
      ks_prog[k] = p;
    end
  end

  always_comb begin : next_state
    len_nxt   = len_r;
    kind_nxt  = kind_r;
    ended_nxt = ended_r;
    phase_nxt = phase_r;
    mag1_nxt  = mag1_r;
    mag2_nxt  = mag2_r;
    signs_nxt = signs_r;
    kwp_nxt   = kwp_r;
    found_nxt = found_r;
    if (accept) begin
      if ((in_rx_byte == CH_NL) || (len_r >= LEN_W'(LINE_BYTES - 1))) begin
        // end of line or overflow: restart empty
        len_nxt   = '0;
        kind_nxt  = LK_EMPTY;
        ended_nxt = 1'b0;
        phase_nxt = PH_BLANK1;
        mag1_nxt  = '0;
        mag2_nxt  = '0;
        signs_nxt = '0;
        for (int k = 0; k < NUM_KW; k++) kwp_nxt[k] = '0;
        found_nxt = '0;
      end else begin
        len_nxt = len_r + 1'b1;
        if (!ended_r) begin
          if (in_rx_byte == CH_NUL) begin
            ended_nxt = 1'b1;
            if (kind_r == LK_EMPTY) kind_nxt = LK_OTHER;
          end else begin
            unique case (kind_r)
              LK_EMPTY: begin
                if (in_rx_byte == CH_HASH) begin
                  kind_nxt = LK_HASH;
                end else if (in_rx_byte == CH_AT) begin
                  kind_nxt  = LK_AT;
                  kwp_nxt   = ks_prog;
                  found_nxt = ks_found;
                end else begin
                  kind_nxt = LK_OTHER;
                end
              end
              LK_HASH: begin
                phase_nxt = ns_phase;
                mag1_nxt  = ns_mag1;
                mag2_nxt  = ns_mag2;
                signs_nxt = ns_signs;
              end
              LK_AT: begin
                kwp_nxt   = ks_prog;
                found_nxt = ks_found;
              end
              default: kind_nxt = kind_r;
            endcase
          end
        end
      end
    end
  end

  always_comb begin : outputs
    logic coord_ok, kw_ok;
    coord_ok = (kind_r == LK_HASH) && ((phase_r == PH_DIG2) || (phase_r == PH_DONE));
    kw_ok    = (kind_r == LK_AT) && (found_r != '0);
    push     = accept && (in_rx_byte == CH_NL) && (coord_ok || kw_ok);
    push_entry.is_coord = coord_ok;
    push_entry.x        = finish_num(mag1_r, signs_r[0]);
    push_entry.y        = finish_num(mag2_r, signs_r[1]);
    if (coord_ok)                 push_entry.code = EV_COORD;
    else if (found_r[KW_CAM_OFF]) push_entry.code = kw_code(KW_CAM_OFF);
    else if (found_r[KW_CAM])     push_entry.code = kw_code(KW_CAM);
    else if (found_r[KW_GO])      push_entry.code = kw_code(KW_GO);
    else                          push_entry.code = kw_code(KW_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      kind_r  <= LK_EMPTY;
      ended_r <= 1'b0;
      phase_r <= PH_BLANK1;
      mag1_r  <= '0;
      mag2_r  <= '0;
      signs_r <= '0;
      for (int k = 0; k < NUM_KW; k++) kwp_r[k] <= '0;
      found_r <= '0;
    end else begin
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
      ended_r <= ended_nxt;
      phase_r <= phase_nxt;
      mag1_r  <= mag1_nxt;
      mag2_r  <= mag2_nxt;
      signs_r <= signs_nxt;
      kwp_r   <= kwp_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

/* rtl/aclp_queue.sv */
// Short register FIFO of line summaries between the parser front and back.
// Depends on aclp_pkg for the entry type and depth.
module aclp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  aclp_pkg::aclp_entry_t push_entry,
  input  logic                  pop,
  output aclp_pkg::aclp_entry_t head,
  output aclp_pkg::aclp_qstat_t qstat
);
  import aclp_pkg::*;

  aclp_entry_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

/* rtl/aclp_back.sv */
// Back end of the parser: applies line summaries to the stored coordinates and drives results.
// Depends on aclp_pkg; drains aclp_queue into a registered output word.
module aclp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aclp_pkg::aclp_entry_t head,
  input  aclp_pkg::aclp_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_code,
  output logic signed [15:0]    out_coord_x,
  output logic signed [15:0]    out_coord_y
);
  import aclp_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] sx_r, sx_nxt;
  logic [15:0] sy_r, sy_nxt;
  ev_code_t    code_r, code_nxt;
  logic [15:0] ox_r, ox_nxt;
  logic [15:0] oy_r, oy_nxt;

  // take a new summary whenever the output word is free or leaves this cycle
  assign pop = !qstat.empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r && out_stall;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    code_nxt  = code_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    if (pop) begin
      valid_nxt = 1'b1;
      code_nxt  = head.code;
      if (head.is_coord) begin
        sx_nxt = head.x;
        sy_nxt = head.y;
        ox_nxt = head.x;
        oy_nxt = head.y;
      end else begin
        ox_nxt = sx_r;
        oy_nxt = sy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
  end

  assign out_valid      = valid_r;
  assign out_event_code = code_r;
  assign out_coord_x    = ox_r;
  assign out_coord_y    = oy_r;

endmodule

/* rtl/aclp_checker.sv */
// Port-level checker for the ASCII command line parser, bound to the top level.
// Depends on aclp_pkg for event codes.
module aclp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_event_code,
  input logic signed [15:0] out_coord_x,
  input logic signed [15:0] out_coord_y
);
  import aclp_pkg::*;

  logic [15:0] last_x_r, last_y_r;

  // Track the coordinates of the last delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_x_r <= out_coord_x;
      last_y_r <= out_coord_y;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_event_code) && $stable(out_coord_x) &&
                               $stable(out_coord_y))
    else $error("result word changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_code <= EV_START))
    else $error("event code out of range");

  a_kw_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code != EV_COORD) |->
      (out_coord_x == last_x_r) && (out_coord_y == last_y_r))
    else $error("keyword result changed the stored coordinates");

endmodule

bind ascii_command_line_parser_unit aclp_checker u_aclp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code),
  .out_coord_x    (out_coord_x),
  .out_coord_y    (out_coord_y)
);
